// ===== rtl/core/gwma_pkg.sv =====
// Package for the greedy weighted matching allocator: field widths, codes, defaults.
// Depends on nothing.
package gwma_pkg;
	localparam int ReqSlotsDef  = 256;
	localparam int ResSlotsDef  = 64;
	localparam int EdgesDef     = 8;
	localparam int KindW        = 2;
	localparam int ReqW         = 8;
	localparam int ResW         = 6;
	localparam int WeightW      = 16;
	localparam int StatusW      = 2;
	localparam int CountW       = 9;

	localparam logic [KindW-1:0] KIND_ADD_REQ = 2'd0;
	localparam logic [KindW-1:0] KIND_ADD_RES = 2'd1;
	localparam logic [KindW-1:0] KIND_ADD_EDGE = 2'd2;
	localparam logic [KindW-1:0] KIND_SLOT_END = 2'd3;

	localparam logic [StatusW-1:0] ST_OK       = 2'd0;
	localparam logic [StatusW-1:0] ST_FULL     = 2'd1;
	localparam logic [StatusW-1:0] ST_BAD_ID   = 2'd2;
	localparam logic [StatusW-1:0] ST_DROPPED  = 2'd3;

	typedef struct packed {
		logic [KindW-1:0]   kind;
		logic [ReqW-1:0]    request_index;
		logic [ResW-1:0]    resource_index;
		logic [WeightW-1:0] request_weight;
	} in_item_t;

	typedef struct packed {
		logic [StatusW-1:0] status;
		logic               has_match;
		logic [ReqW-1:0]    matched_request;
		logic [ResW-1:0]    matched_resource;
		logic [CountW-1:0]  satisfied_total;
		logic               last;
	} out_item_t;
endpackage

// ===== rtl/core/gwma_in_if.sv =====
// Input channel interface of the allocator: valid, ready and one input item.
// Depends on gwma_pkg.
interface gwma_in_if;
	logic                valid;
	logic                ready;
	gwma_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/gwma_out_if.sv =====
// Output channel interface of the allocator: valid, ready and one result item.
// Depends on gwma_pkg.
interface gwma_out_if;
	logic                valid;
	logic                ready;
	gwma_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/greedy_weighted_matching_allocator_core.sv =====
// Greedy weighted matching allocator, top level.
// Add items: the result item is valid once the item has passed S_EXEC and S_EMIT; the next item is
// accepted once that result has been taken.
// A slot end walks the listed resources (S_ORD, S_ORDW, then S_EDGE, S_EDGEW and S_WGT per stored
// edge through one shared weight compare, then S_DECIDE) and ends in S_FIN; a waiting result holds it.
// Reset clears flags, fill counts and counters at once; the memories need no clearing.
module greedy_weighted_matching_allocator_core
	import gwma_pkg::*;
#(
	parameter int REQUEST_SLOTS      = ReqSlotsDef,
	parameter int RESOURCE_SLOTS     = ResSlotsDef,
	parameter int EDGES_PER_RESOURCE = EdgesDef
) (
	input  logic clk,
	input  logic arst_n,
	gwma_in_if.sink    in_ch,
	gwma_out_if.source out_ch
);
	localparam int RQB = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;
	localparam int RSB = (RESOURCE_SLOTS > 1) ? $clog2(RESOURCE_SLOTS) : 1;
	localparam int EB  = (EDGES_PER_RESOURCE > 1) ? $clog2(EDGES_PER_RESOURCE) : 1;
	localparam int FB  = $clog2(EDGES_PER_RESOURCE + 1);
	localparam int CB  = $clog2(RESOURCE_SLOTS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_EMIT, S_ORD, S_ORDW, S_EDGE, S_EDGEW, S_WGT, S_DECIDE, S_FIN
	} state_t;

	// Memories: the weight table, the resource order list and the edge store.
	logic [WeightW-1:0] weight_mem [REQUEST_SLOTS];
	logic [RSB-1:0]     order_mem [RESOURCE_SLOTS];
	logic [RQB-1:0]     edge_mem [RESOURCE_SLOTS*EDGES_PER_RESOURCE];
	logic [WeightW-1:0] weight_rd_q;
	logic [RSB-1:0]     order_rd_q;
	logic [RQB-1:0]     edge_rd_q;

	// Flags and fill counts in flip-flops so that reset clears them at once.
	logic [REQUEST_SLOTS-1:0]  req_present_q, req_taken_q;
	logic [RESOURCE_SLOTS-1:0] res_present_q, res_taken_q;
	logic [FB-1:0]             fill_q [RESOURCE_SLOTS];
	logic [CB-1:0]             res_count_q;
	logic [CountW-1:0]         sat_q;

	state_t            state_q;
	in_item_t          item_q;
	out_item_t         out_q;
	out_item_t         held_q;
	out_item_t         held_last;
	logic              out_valid_q;
	logic [CB-1:0]     pos_q;
	logic [RSB-1:0]    res_q;
	logic [FB-1:0]     edge_q;
	logic [RQB-1:0]    cand_q, best_q;
	logic [WeightW-1:0] best_w_q;
	logic              found_q, any_q;

	logic [RQB-1:0] rq_i;
	logic [RSB-1:0] rs_i;
	logic           rq_ok, rs_ok;
	logic [RSB+EB-1:0] edge_addr;
	logic [StatusW-1:0] exec_status;
	logic           out_free, match_ok, emit_now;

	// Identifiers wider than the table fail the range check.
	assign rq_ok = (32'(item_q.request_index) < REQUEST_SLOTS);
	assign rs_ok = (32'(item_q.resource_index) < RESOURCE_SLOTS);
	assign rq_i  = RQB'(item_q.request_index);
	assign rs_i  = RSB'(item_q.resource_index);

	assign in_ch.ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// The output register can take a new result item when it is empty or being drained.
	assign out_free = !out_valid_q || out_ch.ready;
	assign match_ok = found_q && !res_taken_q[res_q] && !req_taken_q[best_q];
	// A held match goes out when the next match arrives or when the walk ends.
	assign emit_now = (state_q == S_EMIT)
		|| (state_q == S_DECIDE && out_free && match_ok && any_q)
		|| (state_q == S_FIN && out_free);

	always_comb begin
		held_last      = held_q;
		held_last.last = 1'b1;
	end

	// Status of an add item, decided from the flags, fill counts and resource count.
	always_comb begin
		case (item_q.kind)
			KIND_ADD_REQ: begin
				if (!rq_ok || req_present_q[rq_i]) begin
					exec_status = ST_BAD_ID;
				end else begin
					exec_status = ST_OK;
				end
			end
			KIND_ADD_RES: begin
				if (32'(res_count_q) >= RESOURCE_SLOTS) begin
					exec_status = ST_FULL;
				end else if (!rs_ok || res_present_q[rs_i]) begin
					exec_status = ST_BAD_ID;
				end else begin
					exec_status = ST_OK;
				end
			end
			KIND_ADD_EDGE: begin
				if (!rq_ok || !rs_ok || !req_present_q[rq_i] || !res_present_q[rs_i]) begin
					exec_status = ST_BAD_ID;
				end else if (32'(fill_q[rs_i]) >= EDGES_PER_RESOURCE) begin
					exec_status = ST_DROPPED;
				end else begin
					exec_status = ST_OK;
				end
			end
			default: exec_status = ST_OK;
		endcase
	end

	// Memory ports: one write, registered read.
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && item_q.kind == KIND_ADD_REQ && rq_ok && !req_present_q[rq_i]) begin
			weight_mem[rq_i] <= item_q.request_weight;
		end
		// The weight is looked up with the candidate as soon as the edge read returns it.
		weight_rd_q <= weight_mem[edge_rd_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && item_q.kind == KIND_ADD_RES && 32'(res_count_q) < RESOURCE_SLOTS
				&& rs_ok && !res_present_q[rs_i]) begin
			order_mem[RSB'(res_count_q)] <= rs_i;
		end
		order_rd_q <= order_mem[RSB'(pos_q)];
	end

	always_comb begin
		if (state_q == S_EXEC) begin
			edge_addr = (RSB+EB)'(rs_i) * (RSB+EB)'(EDGES_PER_RESOURCE) + (RSB+EB)'(fill_q[rs_i]);
		end else begin
			edge_addr = (RSB+EB)'(res_q) * (RSB+EB)'(EDGES_PER_RESOURCE) + (RSB+EB)'(edge_q);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && item_q.kind == KIND_ADD_EDGE && rq_ok && rs_ok
				&& req_present_q[rq_i] && res_present_q[rs_i]
				&& 32'(fill_q[rs_i]) < EDGES_PER_RESOURCE) begin
			edge_mem[edge_addr] <= rq_i;
		end
		edge_rd_q <= edge_mem[edge_addr];
	end

	// Sequencer: decodes an item, and for a slot end walks resources then edges.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			req_present_q <= '0;
			req_taken_q   <= '0;
			res_present_q <= '0;
			res_taken_q   <= '0;
			res_count_q   <= '0;
			sat_q         <= '0;
			pos_q         <= '0;
			any_q         <= 1'b0;
			for (int i = 0; i < RESOURCE_SLOTS; i++) fill_q[i] <= '0;
		end else begin
			out_valid_q <= emit_now || (out_valid_q && !out_ch.ready);
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						item_q  <= in_ch.data;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					out_q <= '{status: exec_status, has_match: 1'b0, matched_request: '0,
						matched_resource: '0, satisfied_total: sat_q, last: 1'b1};
					case (item_q.kind)
						KIND_ADD_REQ: begin
							if (exec_status == ST_OK) begin
								req_present_q[rq_i] <= 1'b1;
								req_taken_q[rq_i]   <= 1'b0;
							end
							state_q <= S_EMIT;
						end
						KIND_ADD_RES: begin
							if (exec_status == ST_OK) begin
								res_count_q <= res_count_q + 1'b1;
								res_present_q[rs_i] <= 1'b1;
								res_taken_q[rs_i]   <= 1'b0;
							end
							state_q <= S_EMIT;
						end
						KIND_ADD_EDGE: begin
							if (exec_status == ST_OK) begin
								fill_q[rs_i] <= fill_q[rs_i] + 1'b1;
							end
							state_q <= S_EMIT;
						end
						default: begin
							pos_q   <= '0;
							any_q   <= 1'b0;
							state_q <= S_ORD;
						end
					endcase
				end
				S_EMIT: begin
					state_q <= S_IDLE;
				end
				S_ORD: begin
					// Order memory read of pos_q is issued this cycle.
					if (pos_q >= res_count_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_ORDW;
					end
				end
				S_ORDW: begin
					res_q    <= order_rd_q;
					edge_q   <= '0;
					found_q  <= 1'b0;
					best_w_q <= '0;
					best_q   <= '0;
					state_q  <= S_EDGE;
				end
				S_EDGE: begin
					if (edge_q >= fill_q[res_q]) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_EDGEW;
					end
				end
				S_EDGEW: begin
					cand_q  <= edge_rd_q;
					state_q <= S_WGT;
				end
				S_WGT: begin
					// weight_rd_q now holds the weight of cand_q; one shared compare.
					if (!req_taken_q[cand_q] && weight_rd_q > best_w_q) begin
						best_w_q <= weight_rd_q;
						best_q   <= cand_q;
						found_q  <= 1'b1;
					end
					edge_q  <= edge_q + 1'b1;
					state_q <= S_EDGE;
				end
				S_DECIDE: begin
					if (out_free) begin
						fill_q[res_q] <= '0;
						pos_q <= pos_q + 1'b1;
						state_q <= S_ORD;
						if (match_ok) begin
							res_taken_q[res_q]  <= 1'b1;
							req_taken_q[best_q] <= 1'b1;
							if (sat_q != '1) sat_q <= sat_q + 1'b1;
							// The previous match goes out; this one is held until we
							// know whether another follows.
							if (any_q) out_q <= held_q;
							any_q <= 1'b1;
							held_q <= '{status: ST_OK, has_match: 1'b1,
								matched_request: ReqW'(best_q), matched_resource: ResW'(res_q),
								satisfied_total: (sat_q != '1) ? sat_q + 1'b1 : sat_q,
								last: 1'b0};
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						if (!any_q) begin
							out_q <= '{status: ST_OK, has_match: 1'b0, matched_request: '0,
								matched_resource: '0, satisfied_total: sat_q, last: 1'b1};
						end else begin
							out_q <= held_last;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
